// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// No dependencies; take in with a plain include of this file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/ucld_pkg.sv =====
// Package for the UART command line decoder: codes, keyword tables, types.
// No dependencies; imported by every module of the block.
package ucld_pkg;

   localparam int LINE_CHARS_DEF = 16;
   localparam int PULSE_W        = 24;
   localparam logic [PULSE_W-1:0] PULSE_TICKS_RESET = PULSE_W'(300);

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   localparam logic [2:0] CODE_NONE    = 3'd0;
   localparam logic [2:0] CODE_FORWARD = 3'd1;
   localparam logic [2:0] CODE_LEFT    = 3'd2;
   localparam logic [2:0] CODE_RIGHT   = 3'd3;
   localparam logic [2:0] CODE_SEARCH  = 3'd4;
   localparam logic [2:0] CODE_LEDS    = 3'd5;
   localparam logic [2:0] CODE_STOP    = 3'd6;
   localparam logic [2:0] CODE_UNKNOWN = 3'd7;

   localparam logic [1:0] MOTOR_LEFT  = 2'b01;
   localparam logic [1:0] MOTOR_RIGHT = 2'b10;

   localparam int KW_NUM = 6;
   localparam int KW_MAX = 8;

   // keyword k reports code k+1
   localparam int KW_LEN [KW_NUM] = '{7, 4, 5, 6, 4, 4};
   localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX] = '{
      '{"F", "O", "R", "W", "A", "R", "D", 8'h00},
      '{"L", "E", "F", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"R", "I", "G", "H", "T", 8'h00, 8'h00, 8'h00},
      '{"S", "E", "A", "R", "C", "H", 8'h00, 8'h00},
      '{"L", "E", "D", "S", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00}
   };

   typedef struct packed {
      logic left_on;
      logic right_on;
      logic leds_lit;
   } status_type;

endpackage

// ===== rtl/ucld_line_match.sv =====
// Line collector: character count and one running match flag per keyword.
// Depends on ucld_pkg.
module ucld_line_match
   import ucld_pkg::*;
#(
   parameter int LINE_CHARS = LINE_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       is_byte,
   input  logic [7:0] rx_byte,
   output logic [2:0] code
);

   localparam int CW = $clog2(LINE_CHARS + 2);

   logic [CW-1:0]     count_ff, count_in;
   logic [KW_NUM-1:0] flag_ff, flag_in;
   logic              is_eol;

   always_comb begin
      count_in = count_ff;
      flag_in  = flag_ff;
      code     = CODE_NONE;
      is_eol   = is_byte && (rx_byte == CHAR_LF || rx_byte == CHAR_CR);
      if (is_eol) begin
         code = CODE_UNKNOWN;
         // walk backwards so the first keyword in the list wins
         for (int k = KW_NUM - 1; k >= 0; k--) begin
            if (flag_ff[k] && count_ff == CW'(KW_LEN[k])) begin
               code = 3'(k + 1);
            end
         end
         count_in = '0;
         flag_in  = '1;
      end else if (is_byte) begin
         if (count_ff < CW'(LINE_CHARS)) begin
            for (int k = 0; k < KW_NUM; k++) begin
               flag_in[k] = flag_ff[k] && (count_ff < CW'(KW_LEN[k])) &&
                            (rx_byte == KW_TEXT[k][count_ff[2:0]]);
            end
            count_in = count_ff + 1'b1;
         end else begin
            // over-long line, never matches
            count_in = CW'(LINE_CHARS + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flag_ff  <= '1;
      end else if (step) begin
         count_ff <= count_in;
         flag_ff  <= flag_in;
      end
   end

endmodule

// ===== rtl/ucld_actuator.sv =====
// Motor enables and LED pulse counter, driven by decoded commands and ticks.
// Depends on ucld_pkg.
module ucld_actuator
   import ucld_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               is_tick,
   input  logic [2:0]         code,
   input  logic [PULSE_W-1:0] pulse_ticks,
   output status_type         status
);

   logic [1:0]         motors_ff, motors_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;

   always_comb begin
      motors_in = motors_ff;
      pulse_in  = pulse_ff;
      if (is_tick) begin
         if (pulse_ff != '0) begin
            pulse_in = pulse_ff - 1'b1;
         end
      end else begin
         case (code)
            CODE_FORWARD: begin
               motors_in = MOTOR_LEFT | MOTOR_RIGHT;
               pulse_in  = '0;
            end
            CODE_LEFT: begin
               motors_in = MOTOR_RIGHT;
               pulse_in  = '0;
            end
            CODE_RIGHT, CODE_SEARCH: begin
               motors_in = MOTOR_LEFT;
               pulse_in  = '0;
            end
            CODE_LEDS: begin
               motors_in = '0;
               pulse_in  = pulse_ticks;
            end
            CODE_STOP: begin
               motors_in = '0;
               pulse_in  = '0;
            end
            default: begin
               motors_in = motors_ff;
               pulse_in  = pulse_ff;
            end
         endcase
      end
      // status shows the state after this item
      status.left_on  = |(motors_in & MOTOR_LEFT);
      status.right_on = |(motors_in & MOTOR_RIGHT);
      status.leds_lit = (pulse_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motors_ff <= '0;
         pulse_ff  <= '0;
      end else if (step) begin
         motors_ff <= motors_in;
         pulse_ff  <= pulse_in;
      end
   end

endmodule

// ===== rtl/uart_command_line_decoder_unit.sv =====
// Top level of the UART command line decoder: input and result registers, CSR.
// Depends on ucld_pkg, ucld_line_match and ucld_actuator.
//
// Each item is a received byte or a time tick and yields exactly one result,
// which shows the motor enables and LED state after that item together with
// the command code of a line ended by LF or CR. One item is taken every
// cycle unless the result channel stalls; an item passes through the input
// register and then the result register to the result channel. Keyword
// matching runs on per-keyword flags updated per byte, so no line buffer is
// read at line end. The LED pulse length is written over the csr_ channel,
// which is always ready and takes effect for the next LEDS command.
module uart_command_line_decoder_unit
   import ucld_pkg::*;
#(
   parameter int LINE_CHARS = LINE_CHARS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] rx_byte
   input  logic               req_tuser,   // [0] op: 0 byte, 1 tick
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [0] left_motor_on, [1] right_motor_on,
                                           // [2] leds_lit, [5:3] command_code, [7:6] zero
   input  logic               csr_tvalid,
   output logic               csr_tready,
   input  logic [PULSE_W-1:0] csr_tdata    // [23:0] pulse_ticks
);

   logic               in_valid_ff, in_valid_in;
   logic               in_op_ff, in_op_in;
   logic [7:0]         in_byte_ff, in_byte_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_data_ff, out_data_in;
   logic [PULSE_W-1:0] pulse_ticks_ff, pulse_ticks_in;
   logic               req_accept, advance;
   logic [2:0]         code;
   status_type         status;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_tready = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   ucld_line_match #(
      .LINE_CHARS (LINE_CHARS)
   ) u_line_match (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .is_byte (!in_op_ff),
      .rx_byte (in_byte_ff),
      .code    (code)
   );

   ucld_actuator u_actuator (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .is_tick     (in_op_ff),
      .code        (code),
      .pulse_ticks (pulse_ticks_ff),
      .status      (status)
   );

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_op_in       = in_op_ff;
      in_byte_in     = in_byte_ff;
      out_valid_in   = out_valid_ff;
      out_data_in    = out_data_ff;
      pulse_ticks_in = pulse_ticks_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_op_in    = req_tuser;
         in_byte_in  = req_tdata;
      end
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = {2'b00, code, status.leds_lit, status.right_on, status.left_on};
      end
      if (csr_tvalid) begin
         pulse_ticks_in = csr_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         pulse_ticks_ff <= PULSE_TICKS_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         pulse_ticks_ff <= pulse_ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff    <= in_op_in;
      in_byte_ff  <= in_byte_in;
      out_data_ff <= out_data_in;
   end

endmodule

// ===== rtl/ucld_checker.sv =====
// Port-level checks on the result channel of the command line decoder.
// Depends on ucld_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module ucld_checker
   import ucld_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   `ASSERT_ALL(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")
   `ASSERT_RUN(a_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `ASSERT_RUN(a_leds_stops, rsp_tvalid && rsp_tdata[5:3] == CODE_LEDS |-> rsp_tdata[1:0] == 2'b00, "LEDS left a motor on")
   `ASSERT_RUN(a_stop_all, rsp_tvalid && rsp_tdata[5:3] == CODE_STOP |-> rsp_tdata[2:0] == 3'b000, "STOP left an output on")
   `ASSERT_RUN(a_fwd_both, rsp_tvalid && rsp_tdata[5:3] == CODE_FORWARD |-> rsp_tdata[2:0] == 3'b011, "FORWARD outputs wrong")

endmodule

bind uart_command_line_decoder_unit ucld_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb.sv =====
// Self-checking testbench for uart_command_line_decoder_unit: drives bytes and ticks,
// predicts motor/LED state and command codes, checks each result item.
// Depends on ucld_pkg and the RTL of the decoder only.
module tb;
   import ucld_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_CHARS  = LINE_CHARS_DEF;
   localparam int LATENCY     = 2;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEM_TARGET = 1600;

   typedef struct {
      logic       left_on;
      logic       right_on;
      logic       leds_on;
      logic [2:0] code;
   } expect_type;

   typedef enum int {
      READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PATTERN
   } ready_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata = 8'h00;   // [7:0] rx_byte
   logic               req_tuser = 1'b0;    // [0] op: 0 byte, 1 tick
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;           // [0] left, [1] right, [2] leds, [5:3] code
   logic               csr_tvalid = 1'b0;
   logic               csr_tready;
   logic [PULSE_W-1:0] csr_tdata = '0;      // [23:0] pulse_ticks

   uart_command_line_decoder_unit #(.LINE_CHARS(LINE_CHARS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always #6 clock = ~clock;

   // decoder shadow state
   logic [7:0]         line_buf [LINE_CHARS];
   int                 line_len = 0;
   logic [1:0]         motors = '0;
   logic [PULSE_W-1:0] pulse_left = '0;
   logic [PULSE_W-1:0] pulse_len = PULSE_TICKS_RESET;

   expect_type status_q [$];
   logic [7:0] line_q [$];
   int         errors = 0;
   int         items_sent = 0;
   int         results_seen = 0;
   int         lit_seen = 0;
   int         settings_used = 0;
   int         code_seen [8];
   int         burst_left = 0;
   bit         gaps_on = 1'b1;
   bit         hold_toggle = 1'b0;

   function automatic string keyword_text(int c);
      case (c)
         CODE_FORWARD: return "FORWARD";
         CODE_LEFT:    return "LEFT";
         CODE_RIGHT:   return "RIGHT";
         CODE_SEARCH:  return "SEARCH";
         CODE_LEDS:    return "LEDS";
         default:      return "STOP";
      endcase
   endfunction

   function automatic logic [2:0] close_line();
      logic [2:0] code;
      string      word;
      bit         hit;
      code = CODE_UNKNOWN;
      // an over-long line sits at LINE_CHARS + 1 and can never match
      if (line_len <= LINE_CHARS) begin
         for (int c = CODE_FORWARD; c <= CODE_STOP; c++) begin
            word = keyword_text(c);
            hit = (word.len() == line_len) && (code == CODE_UNKNOWN);
            for (int i = 0; i < word.len() && hit; i++)
               if (line_buf[i] != word[i]) hit = 1'b0;
            if (hit) begin
               code = 3'(c);
               case (code)
                  CODE_FORWARD: motors = MOTOR_LEFT | MOTOR_RIGHT;
                  CODE_LEFT:    motors = MOTOR_RIGHT;
                  CODE_RIGHT:   motors = MOTOR_LEFT;
                  CODE_SEARCH:  motors = MOTOR_LEFT;
                  default:      motors = '0;
               endcase
               pulse_left = (code == CODE_LEDS) ? pulse_len : '0;
            end
         end
      end
      line_len = 0;
      return code;
   endfunction

   function automatic expect_type predict_status(logic op, logic [7:0] rx);
      expect_type s;
      s.code = CODE_NONE;
      if (op) begin
         if (pulse_left != 0) pulse_left = pulse_left - 1'b1;
      end else if (rx == CHAR_LF || rx == CHAR_CR) begin
         s.code = close_line();
      end else if (line_len < LINE_CHARS) begin
         line_buf[line_len] = rx;
         line_len++;
      end else begin
         line_len = LINE_CHARS + 1;
      end
      s.left_on  = motors[0];
      s.right_on = motors[1];
      s.leds_on  = (pulse_left != 0);
      return s;
   endfunction

   task automatic send_item(logic op, logic [7:0] rx);
      int gap;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      status_q.push_back(predict_status(op, rx));
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(1'b1, 8'($urandom));
   endtask

   task automatic append_text(string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   // sends line_q then the terminator; tick_odds of 0 means no ticks in between
   task automatic send_line(bit use_cr, int tick_odds);
      foreach (line_q[i]) begin
         if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) send_tick();
         send_item(1'b0, line_q[i]);
      end
      send_item(1'b0, use_cr ? CHAR_CR : CHAR_LF);
      line_q.delete();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_pulse_ticks(logic [PULSE_W-1:0] value);
      csr_tvalid <= 1'b1;
      csr_tdata  <= value;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
      pulse_len = value;
      settings_used++;
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      expect_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         code_seen[rsp_tdata[5:3]]++;
         if (rsp_tdata[2]) lit_seen++;
         if (status_q.size() == 0) begin
            $display("%0t: unexpected result item, expected none, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = status_q.pop_front();
            check_field("left_motor_on", want.left_on, rsp_tdata[0]);
            check_field("right_motor_on", want.right_on, rsp_tdata[1]);
            check_field("leds_lit", want.leds_on, rsp_tdata[2]);
            check_field("command_code", want.code, rsp_tdata[5:3]);
            check_field("padding", 0, rsp_tdata[7:6]);
         end
      end
   end

   // receiver: changing stall modes, plus a long hold-off on request
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left = 0;
   int             hold_left = 0;
   bit             hold_seen = 1'b0;
   logic [7:0]     ready_pat = 8'b1101_1001;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(32, 256);
         end else begin
            mode_left <= mode_left - 1;
         end
         ready_pat <= {ready_pat[6:0], ready_pat[7]};
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= ready_pat[7];
         endcase
      end
   end

   // empty line, zero byte, LED pulse, tick with no pulse, over-long line
   task automatic test_directed();
      write_pulse_ticks(PULSE_W'(2));
      send_tick();
      send_line(1'b0, 0);
      line_q.push_back(8'h00);
      send_line(1'b1, 0);
      append_text("LEDS");
      send_line(1'b0, 0);
      send_tick();
      send_tick();
      append_text("FORWARDFORWARDFOR");
      line_q[3] = 8'hFF;
      line_q[9] = 8'h80;
      send_line(1'b1, 0);
      drain();
   endtask

   // LEDS under zero, shortest and longest pulse settings, cut short by STOP, or by LEFT for the longest
   task automatic test_pulse_settings();
      logic [PULSE_W-1:0] values [3];
      values = '{'0, PULSE_W'(1), '1};
      foreach (values[i]) begin
         write_pulse_ticks(values[i]);
         append_text("LEDS");
         send_line(1'b0, 0);
         send_tick();
         send_tick();
         append_text(i == 2 ? "LEFT" : "STOP");
         send_line(1'b1, 0);
         drain();
      end
   endtask

   task automatic random_line();
      int    kind;
      int    c;
      int    n;
      int    pos;
      string word;
      kind = $urandom_range(0, 99);
      c = $urandom_range(CODE_FORWARD, CODE_STOP);
      word = keyword_text(c);
      if (kind < 50) begin
         append_text(word);
      end else if (kind < 62) begin
         // one bit flipped, which includes a change of letter case
         append_text(word);
         pos = $urandom_range(0, word.len() - 1);
         line_q[pos] = line_q[pos] ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind < 70) begin
         append_text(word);
         if ($urandom_range(0, 1)) void'(line_q.pop_back());
         else line_q.push_back(8'($urandom_range(32, 126)));
      end else if (kind < 82) begin
         n = $urandom_range(1, LINE_CHARS);
         repeat (n) line_q.push_back(8'($urandom));
      end else if (kind < 88) begin
         n = $urandom_range(LINE_CHARS, LINE_CHARS + 8);
         repeat (n) line_q.push_back(8'($urandom_range(32, 255)));
      end else if (kind < 92) begin
         // empty line
      end else begin
         repeat ($urandom_range(1, 4)) send_tick();
         return;
      end
      send_line(1'($urandom_range(0, 1)), 8);
      if (c == CODE_LEDS || $urandom_range(0, 3) == 0)
         repeat ($urandom_range(0, 12)) send_tick();
   endtask

   task automatic test_random();
      int goal;
      for (int blk = 0; items_sent < ITEM_TARGET; blk++) begin
         drain();
         case (blk % 8)
            5:       write_pulse_ticks('1);
            6:       write_pulse_ticks(PULSE_TICKS_RESET);
            default: write_pulse_ticks(PULSE_W'($urandom_range(1, 12)));
         endcase
         gaps_on = (blk % 3 != 2);
         goal = items_sent + 200;
         while (items_sent < goal) random_line();
      end
      gaps_on = 1'b1;
      drain();
   endtask

   // receiver holds off while the sender keeps offering, then everything drains
   task automatic test_backpressure();
      int goal;
      gaps_on = 1'b0;
      hold_toggle <= ~hold_toggle;
      goal = items_sent + 60;
      while (items_sent < goal) random_line();
      gaps_on = 1'b1;
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pulse_settings();
      test_backpressure();
      test_random();
      $display("Covered %0d items and %0d results over %0d pulse settings, LEDs lit in %0d.",
               items_sent, results_seen, settings_used, lit_seen);
      $display("Codes none/fwd/left/right/search/leds/stop/unknown: %0d %0d %0d %0d",
               code_seen[0], code_seen[1], code_seen[2], code_seen[3]);
      $display("   %0d %0d %0d %0d",
               code_seen[4], code_seen[5], code_seen[6], code_seen[7]);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d result items outstanding", status_q.size());
      $display("FAIL");
      $finish;
   end

endmodule
